FILE: rtl/vertex_normal_accumulator_core_defines.svh
// Assertion macros shared by the vertex normal accumulator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VNA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define VNA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vna_pkg.sv
// Shared types, constants and helper functions of the vertex normal accumulator.
// No dependencies; imported by every module of the block except vna_fifo.
package vna_pkg;

    localparam int VERTEX_COUNT_DEF = 1024;
    localparam int VIDX_W = 10;
    localparam int MAX_DEPTH = 1024;
    localparam int POS_W = 24;
    localparam int SUM_W = 24;
    localparam int NRM_W = 16;
    localparam int THR_W = 32;
    localparam logic [THR_W-1:0] THR_RESET = 32'd4295;
    localparam int EDGE_W = 25;
    localparam int VEC_W = 51;
    localparam int ONE_Q14 = 16384;
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int OUT_FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        K_WRITE    = 2'd0,
        K_TRIANGLE = 2'd1,
        K_READ     = 2'd2,
        K_NONE     = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [VIDX_W-1:0]        va;
        logic [VIDX_W-1:0]        vb;
        logic [VIDX_W-1:0]        vc;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
    } t_cmd;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic                    zero;
    } t_nres;

    // Reduces a vertex index modulo the vertex count by restoring subtraction.
    function automatic logic [VIDX_W-1:0] idx_mod(input logic [VIDX_W-1:0] v,
                                                  input int unsigned vc);
        logic [31:0] r;
        logic [31:0] d;
        r = 32'(v);
        for (int k = VIDX_W - 1; k >= 0; k--) begin
            d = vc << k;
            if ((vc << k) >> k == vc && d <= r) begin
                r = r - d;
            end
        end
        return r[VIDX_W-1:0];
    endfunction

endpackage

FILE: rtl/vertex_normal_accumulator_core.sv
// Smooth vertex normal accumulator: writes store positions, triangles add unit face
// normals to their corners, reads return normalized vertex sums. After reset the block
// clears all min(VERTEX_COUNT, 1024) entries of its position and sum memories, one
// entry a cycle, and holds full high meanwhile. Items are then carried out one at a
// time by a sequencer behind a two-item command queue; a read of a zero sum skips the
// normalizing steps, and a triangle whose face is under the threshold is not added.
// The time of reads and triangles is set by the shared normalizer: up to 19 shift steps,
// a 32-step square root and a bit-serial divide for each of the three components.
// Depends on vna_pkg, vna_fifo, vna_front and vna_back.
module vertex_normal_accumulator_core import vna_pkg::*; #(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              i_kind,
    input  logic [VIDX_W-1:0]       i_vertex_a,
    input  logic [VIDX_W-1:0]       i_vertex_b,
    input  logic [VIDX_W-1:0]       i_vertex_c,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [NRM_W-1:0] o_normal_x,
    output logic signed [NRM_W-1:0] o_normal_y,
    output logic signed [NRM_W-1:0] o_normal_z,
    output logic                    o_zero_length,
    input  logic                    i_cfg_we,
    input  logic [THR_W-1:0]        i_cfg_wdata
);
    t_cmd  w_front_cmd;
    t_cmd  w_back_cmd;
    logic  w_front_push;
    logic  w_cmd_full;
    logic  w_cmd_empty;
    logic  w_cmd_pop;
    logic  w_clearing;
    t_nres w_res;
    t_nres w_head;
    logic  w_res_push;
    logic  w_res_full;

    vna_front #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (w_clearing),
        .i_push     (push),
        .o_full     (full),
        .i_kind     (i_kind),
        .i_vertex_a (i_vertex_a),
        .i_vertex_b (i_vertex_b),
        .i_vertex_c (i_vertex_c),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .o_cmd      (w_front_cmd),
        .o_cmd_push (w_front_push),
        .i_cmd_full (w_cmd_full)
    );

    vna_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_data  (w_front_cmd),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_back_cmd),
        .o_empty (w_cmd_empty)
    );

    vna_back #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_clearing  (w_clearing),
        .i_cmd       (w_back_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (w_res),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full)
    );

    vna_fifo #(
        .WIDTH ($bits(t_nres)),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_head),
        .o_empty (empty)
    );

    assign o_normal_x    = w_head.nx;
    assign o_normal_y    = w_head.ny;
    assign o_normal_z    = w_head.nz;
    assign o_zero_length = w_head.zero;

endmodule

FILE: rtl/vna_fifo.sv
// Small register queue used between the front and back parts and on the result side.
// Depends on nothing but its parameters.
module vna_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [PW:0]      r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/vna_front.sv
// Front part: accepts items, drops unused kinds and reduces vertex indices.
// Depends on vna_pkg.
module vna_front import vna_pkg::*; #(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_hold,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [1:0]              i_kind,
    input  logic [VIDX_W-1:0]       i_vertex_a,
    input  logic [VIDX_W-1:0]       i_vertex_b,
    input  logic [VIDX_W-1:0]       i_vertex_c,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    output t_cmd                    o_cmd,
    output logic                    o_cmd_push,
    input  logic                    i_cmd_full
);
    logic r_valid;
    t_cmd r_cmd;
    logic w_acc;

    assign o_full     = i_hold || (r_valid && i_cmd_full);
    assign w_acc      = i_push && !o_full;
    assign o_cmd_push = r_valid && !i_cmd_full;

    always_comb begin
        o_cmd    = r_cmd;
        o_cmd.va = idx_mod(r_cmd.va, VERTEX_COUNT);
        o_cmd.vb = idx_mod(r_cmd.vb, VERTEX_COUNT);
        o_cmd.vc = idx_mod(r_cmd.vc, VERTEX_COUNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= (t_kind'(i_kind) != K_NONE);
        end else if (o_cmd_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd.kind <= t_kind'(i_kind);
            r_cmd.va   <= i_vertex_a;
            r_cmd.vb   <= i_vertex_b;
            r_cmd.vc   <= i_vertex_c;
            r_cmd.px   <= i_pos_x;
            r_cmd.py   <= i_pos_y;
            r_cmd.pz   <= i_pos_z;
        end
    end

endmodule

FILE: rtl/vna_norm.sv
// Normalizing unit: shift to 30 bits, sum of squares, bit-serial square root and divide.
// Depends on vna_pkg.
module vna_norm import vna_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [VEC_W-1:0] i_vec_x,
    input  logic signed [VEC_W-1:0] i_vec_y,
    input  logic signed [VEC_W-1:0] i_vec_z,
    output logic                    o_done,
    output t_nres                   o_res
);
    localparam int SH_W = 30;
    localparam int ROOT_W = 64;
    localparam int LEN_W = 31;
    localparam int FRAC_W = 14;
    localparam int Q_W = 15;
    localparam int NUM_W = SH_W + FRAC_W + 2;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(ONE_Q14);

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DINIT, N_DIV, N_DONE
    } t_nstate;

    t_nstate                 r_state;
    logic [VEC_W-1:0]        r_a [3];
    logic [2:0]              r_neg;
    logic [1:0]              r_step;
    logic [2*SH_W-1:0]       r_prod;
    logic [ROOT_W-1:0]       r_x;
    logic [ROOT_W-1:0]       r_res;
    logic [4:0]              r_k;
    logic [NUM_W-1:0]        r_num;
    logic [Q_W-2:0]          r_q;
    logic [3:0]              r_dk;
    logic signed [NRM_W-1:0] r_n [3];
    logic                    r_zero;
    logic                    r_done;

    logic [VEC_W-1:0]        w_mag [3];
    logic                    w_top;
    logic [SH_W-1:0]         w_asel;
    logic                    w_nsel;
    logic [ROOT_W-1:0]       w_bit;
    logic [ROOT_W-1:0]       w_trial;
    logic [LEN_W-1:0]        w_len;
    logic [NUM_W-1:0]        w_dsub;
    logic                    w_ge;
    logic [Q_W-1:0]          w_qfin;
    logic [Q_W-1:0]          w_qcap;
    logic signed [NRM_W-1:0] w_nval;

    always_comb begin
        w_mag[0] = i_vec_x[VEC_W-1] ? VEC_W'(-i_vec_x) : VEC_W'(i_vec_x);
        w_mag[1] = i_vec_y[VEC_W-1] ? VEC_W'(-i_vec_y) : VEC_W'(i_vec_y);
        w_mag[2] = i_vec_z[VEC_W-1] ? VEC_W'(-i_vec_z) : VEC_W'(i_vec_z);
        w_top    = |(r_a[0][VEC_W-1:SH_W] | r_a[1][VEC_W-1:SH_W] | r_a[2][VEC_W-1:SH_W]);
        unique case (r_step)
            2'd0:    begin w_asel = r_a[0][SH_W-1:0]; w_nsel = r_neg[0]; end
            2'd1:    begin w_asel = r_a[1][SH_W-1:0]; w_nsel = r_neg[1]; end
            default: begin w_asel = r_a[2][SH_W-1:0]; w_nsel = r_neg[2]; end
        endcase
        w_bit   = ROOT_W'(1) << {r_k, 1'b0};
        w_trial = r_res + w_bit;
        w_len   = r_res[LEN_W-1:0];
        w_dsub  = NUM_W'(w_len) << r_dk;
        w_ge    = (r_num >= w_dsub);
        w_qfin  = {r_q, w_ge};
        w_qcap  = (w_qfin > Q_ONE) ? Q_ONE : w_qfin;
        w_nval  = w_nsel ? -$signed({1'b0, w_qcap}) : $signed({1'b0, w_qcap});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_a[0] <= w_mag[0];
                        r_a[1] <= w_mag[1];
                        r_a[2] <= w_mag[2];
                        r_neg  <= {i_vec_z[VEC_W-1], i_vec_y[VEC_W-1], i_vec_x[VEC_W-1]};
                        if (i_vec_x == '0 && i_vec_y == '0 && i_vec_z == '0) begin
                            r_zero  <= 1'b1;
                            r_n[0]  <= '0;
                            r_n[1]  <= '0;
                            r_n[2]  <= '0;
                            r_state <= N_DONE;
                        end else begin
                            r_zero  <= 1'b0;
                            r_state <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT: begin
                    if (w_top) begin
                        r_a[0] <= r_a[0] >> 1;
                        r_a[1] <= r_a[1] >> 1;
                        r_a[2] <= r_a[2] >> 1;
                    end else begin
                        r_step  <= '0;
                        r_x     <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_prod <= w_asel * w_asel;
                    if (r_step != 2'd0) begin
                        r_x <= r_x + ROOT_W'(r_prod);
                    end
                    if (r_step == 2'd3) begin
                        r_res   <= '0;
                        r_k     <= 5'd31;
                        r_state <= N_SQRT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                N_SQRT: begin
                    if (r_x >= w_trial) begin
                        r_x   <= r_x - w_trial;
                        r_res <= (r_res >> 1) + w_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    if (r_k == '0) begin
                        r_step  <= '0;
                        r_state <= N_DINIT;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
                N_DINIT: begin
                    r_num   <= NUM_W'({w_asel, FRAC_W'(0)}) + NUM_W'(w_len >> 1);
                    r_q     <= '0;
                    r_dk    <= 4'(Q_W - 1);
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    if (w_ge) begin
                        r_num <= r_num - w_dsub;
                    end
                    r_q <= w_qfin[Q_W-2:0];
                    if (r_dk == '0) begin
                        r_n[r_step] <= w_nval;
                        if (r_step == 2'd2) begin
                            r_state <= N_DONE;
                        end else begin
                            r_step  <= r_step + 1'b1;
                            r_state <= N_DINIT;
                        end
                    end else begin
                        r_dk <= r_dk - 1'b1;
                    end
                end
                N_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= N_IDLE;
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_res.nx   = r_n[0];
    assign o_res.ny   = r_n[1];
    assign o_res.nz   = r_n[2];
    assign o_res.zero = r_zero;

endmodule

FILE: rtl/vna_back.sv
// Back part: position and sum memories, cross product, threshold test and accumulation.
// Depends on vna_pkg, vna_norm and the assertion macro header.
`include "vertex_normal_accumulator_core_defines.svh"
module vna_back import vna_pkg::*; #(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata,
    output logic             o_clearing,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    output t_nres            o_res,
    output logic             o_res_push,
    input  logic             i_res_full
);
    localparam int DEPTH = (VERTEX_COUNT < MAX_DEPTH) ? VERTEX_COUNT : MAX_DEPTH;
    localparam int AW = $clog2(DEPTH);
    localparam logic signed [VEC_W-1:0] C_LIM = VEC_W'(65536);
    localparam logic signed [SUM_W:0] S_MAX = (SUM_W+1)'(8388607);
    localparam logic signed [SUM_W:0] S_MIN = -(SUM_W+1)'(8388608);

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_vec3;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_RD_REQ, S_RD_NORM, S_NORM_WAIT, S_RES,
        S_T_RDA, S_T_RDB, S_T_RDC, S_T_CAPC, S_T_MUL, S_T_SQ, S_T_CHK,
        S_T_RMW_RD, S_T_RMW_WR
    } t_state;

    t_vec3 r_pos_mem [DEPTH];
    t_vec3 r_sum_mem [DEPTH];
    t_vec3 r_pos_q;
    t_vec3 r_sum_q;

    t_state                   r_state;
    logic [AW-1:0]            r_clr;
    logic [THR_W-1:0]         r_thr;
    t_cmd                     r_cmd;
    t_vec3                    r_pa;
    t_vec3                    r_pb;
    logic signed [EDGE_W-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [2*EDGE_W-1:0] r_prod;
    logic signed [VEC_W-1:0]  r_c [3];
    logic [2:0]               r_step;
    logic                     r_big;
    logic [THR_W+1:0]         r_sq;
    logic                     r_is_tri;
    logic [1:0]               r_corner;
    logic                     r_nstart;
    logic signed [VEC_W-1:0]  r_vx, r_vy, r_vz;
    t_nres                    r_nres;

    logic                     w_pos_we, w_pos_re, w_sum_we, w_sum_re;
    logic [AW-1:0]            w_pos_waddr, w_pos_raddr, w_sum_waddr, w_sum_raddr;
    t_vec3                    w_pos_wd, w_sum_wd, w_sat;
    logic [AW-1:0]            w_ia, w_ib, w_ic, w_corner_addr;
    logic signed [EDGE_W-1:0] w_ma, w_mb;
    logic signed [VEC_W-1:0]  w_csel;
    logic [2:0]               w_j;
    logic                     w_ndone;
    t_nres                    w_nres;

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                        input logic signed [NRM_W-1:0] n);
        logic signed [SUM_W:0] t;
        t = $signed({s[SUM_W-1], s}) + $signed({{(SUM_W+1-NRM_W){n[NRM_W-1]}}, n});
        if (t > S_MAX) begin
            return S_MAX[SUM_W-1:0];
        end else if (t < S_MIN) begin
            return S_MIN[SUM_W-1:0];
        end
        return t[SUM_W-1:0];
    endfunction

    assign w_ia = r_cmd.va[AW-1:0];
    assign w_ib = r_cmd.vb[AW-1:0];
    assign w_ic = r_cmd.vc[AW-1:0];
    assign w_j  = r_step - 3'd1;

    always_comb begin
        unique case (r_corner)
            2'd0:    w_corner_addr = w_ia;
            2'd1:    w_corner_addr = w_ib;
            default: w_corner_addr = w_ic;
        endcase
        w_sat.x = sat_add(r_sum_q.x, r_nres.nx);
        w_sat.y = sat_add(r_sum_q.y, r_nres.ny);
        w_sat.z = sat_add(r_sum_q.z, r_nres.nz);
    end

    always_comb begin
        w_pos_we    = 1'b0;
        w_pos_re    = 1'b0;
        w_sum_we    = 1'b0;
        w_sum_re    = 1'b0;
        w_pos_waddr = w_ia;
        w_pos_raddr = w_ia;
        w_sum_waddr = w_ia;
        w_sum_raddr = w_ia;
        w_pos_wd    = '0;
        w_sum_wd    = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_pos_we    = 1'b1;
                w_sum_we    = 1'b1;
                w_pos_waddr = r_clr;
                w_sum_waddr = r_clr;
            end
            S_WRITE: begin
                w_pos_we   = 1'b1;
                w_sum_we   = 1'b1;
                w_pos_wd.x = r_cmd.px;
                w_pos_wd.y = r_cmd.py;
                w_pos_wd.z = r_cmd.pz;
            end
            S_RD_REQ: w_sum_re = 1'b1;
            S_T_RDA:  w_pos_re = 1'b1;
            S_T_RDB: begin
                w_pos_re    = 1'b1;
                w_pos_raddr = w_ib;
            end
            S_T_RDC: begin
                w_pos_re    = 1'b1;
                w_pos_raddr = w_ic;
            end
            S_T_RMW_RD: begin
                w_sum_re    = 1'b1;
                w_sum_raddr = w_corner_addr;
            end
            S_T_RMW_WR: begin
                w_sum_we    = 1'b1;
                w_sum_waddr = w_corner_addr;
                w_sum_wd    = w_sat;
            end
            default: begin
                w_pos_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (r_step)
            3'd0:    w_csel = r_c[0];
            3'd1:    w_csel = r_c[1];
            default: w_csel = r_c[2];
        endcase
        if (r_state == S_T_SQ) begin
            w_ma = w_csel[EDGE_W-1:0];
            w_mb = w_csel[EDGE_W-1:0];
        end else begin
            unique case (r_step)
                3'd0:    begin w_ma = r_e1y; w_mb = r_e2z; end
                3'd1:    begin w_ma = r_e1z; w_mb = r_e2y; end
                3'd2:    begin w_ma = r_e1z; w_mb = r_e2x; end
                3'd3:    begin w_ma = r_e1x; w_mb = r_e2z; end
                3'd4:    begin w_ma = r_e1x; w_mb = r_e2y; end
                default: begin w_ma = r_e1y; w_mb = r_e2x; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pos_we) begin
            r_pos_mem[w_pos_waddr] <= w_pos_wd;
        end
        if (w_pos_re) begin
            r_pos_q <= r_pos_mem[w_pos_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sum_we) begin
            r_sum_mem[w_sum_waddr] <= w_sum_wd;
        end
        if (w_sum_re) begin
            r_sum_q <= r_sum_mem[w_sum_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_res_push = (r_state == S_RES) && !i_res_full;
    assign o_res      = r_nres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_nstart <= 1'b0;
        end else begin
            r_nstart <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.kind)
                            K_WRITE:    r_state <= S_WRITE;
                            K_TRIANGLE: r_state <= S_T_RDA;
                            K_READ:     r_state <= S_RD_REQ;
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WRITE:  r_state <= S_IDLE;
                S_RD_REQ: r_state <= S_RD_NORM;
                S_RD_NORM: begin
                    r_vx     <= VEC_W'(r_sum_q.x);
                    r_vy     <= VEC_W'(r_sum_q.y);
                    r_vz     <= VEC_W'(r_sum_q.z);
                    r_is_tri <= 1'b0;
                    r_nstart <= 1'b1;
                    r_state  <= S_NORM_WAIT;
                end
                S_NORM_WAIT: begin
                    if (w_ndone) begin
                        r_nres <= w_nres;
                        if (r_is_tri) begin
                            r_corner <= '0;
                            r_state  <= S_T_RMW_RD;
                        end else begin
                            r_state <= S_RES;
                        end
                    end
                end
                S_RES: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                S_T_RDA: r_state <= S_T_RDB;
                S_T_RDB: begin
                    r_pa    <= r_pos_q;
                    r_state <= S_T_RDC;
                end
                S_T_RDC: begin
                    r_pb    <= r_pos_q;
                    r_state <= S_T_CAPC;
                end
                S_T_CAPC: begin
                    r_e1x   <= EDGE_W'(r_pb.x) - EDGE_W'(r_pa.x);
                    r_e1y   <= EDGE_W'(r_pb.y) - EDGE_W'(r_pa.y);
                    r_e1z   <= EDGE_W'(r_pb.z) - EDGE_W'(r_pa.z);
                    r_e2x   <= EDGE_W'(r_pos_q.x) - EDGE_W'(r_pa.x);
                    r_e2y   <= EDGE_W'(r_pos_q.y) - EDGE_W'(r_pa.y);
                    r_e2z   <= EDGE_W'(r_pos_q.z) - EDGE_W'(r_pa.z);
                    r_step  <= '0;
                    r_state <= S_T_MUL;
                end
                S_T_MUL: begin
                    r_prod <= w_ma * w_mb;
                    if (r_step != 3'd0) begin
                        if (!w_j[0]) begin
                            r_c[w_j[2:1]] <= VEC_W'(r_prod);
                        end else begin
                            r_c[w_j[2:1]] <= r_c[w_j[2:1]] - VEC_W'(r_prod);
                        end
                    end
                    if (r_step == 3'd6) begin
                        r_step  <= '0;
                        r_sq    <= '0;
                        r_big   <= 1'b0;
                        r_state <= S_T_SQ;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_T_SQ: begin
                    r_prod <= w_ma * w_mb;
                    if (r_step != 3'd3 && (w_csel >= C_LIM || w_csel <= -C_LIM)) begin
                        r_big <= 1'b1;
                    end
                    if (r_step != 3'd0) begin
                        r_sq <= r_sq + (THR_W+2)'(r_prod[THR_W+1:0]);
                    end
                    if (r_step == 3'd3) begin
                        r_state <= S_T_CHK;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_T_CHK: begin
                    if (!r_big && r_sq <= (THR_W+2)'(r_thr)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_vx     <= r_c[0];
                        r_vy     <= r_c[1];
                        r_vz     <= r_c[2];
                        r_is_tri <= 1'b1;
                        r_nstart <= 1'b1;
                        r_state  <= S_NORM_WAIT;
                    end
                end
                S_T_RMW_RD: r_state <= S_T_RMW_WR;
                S_T_RMW_WR: begin
                    if (r_corner == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_corner <= r_corner + 1'b1;
                        r_state  <= S_T_RMW_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    vna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_nstart),
        .i_vec_x (r_vx),
        .i_vec_y (r_vy),
        .i_vec_z (r_vz),
        .o_done  (w_ndone),
        .o_res   (w_nres)
    );

    `VNA_ASSERT_IMPL(a_no_pop_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_cmd_pop, "Command taken during the clearing pass.")
    `VNA_ASSERT_IMPL(a_start_waits, i_clk, i_rst_n, r_nstart, r_state == S_NORM_WAIT, "Normalizer started outside the wait state.")
    `VNA_ASSERT_IMPL(a_done_expected, i_clk, i_rst_n, w_ndone, r_state == S_NORM_WAIT, "Normalizer finished while nobody waited.")
    `VNA_ASSERT_NEXT(a_pop_leaves_idle, i_clk, i_rst_n, o_cmd_pop, r_state != S_IDLE, "A popped command did not start any work.")

endmodule
